FILE: design/pcs_pkg.sv
// Shared types and constants for the PWM capture statistics block.
package pcs_pkg;

    localparam int TICK_WIDTH = 24;
    localparam int REG_W    = 24;
    localparam int DUTY_W   = 14;
    localparam int PER_W    = 24;
    localparam int FREQ_W   = 26;
    localparam int CNT_W    = 24;
    localparam int DSUM_W   = 38;
    localparam int PSUM_W   = 48;
    localparam int FSUM_W   = 48;
    localparam int DIV_W    = 48;
    localparam int DIVR_W   = 24;
    localparam int IDX_W    = 2;
    localparam int OUT_W    = 216;

    localparam logic [REG_W-1:0]  WINDOW_RESET  = 24'd500000;
    localparam logic [REG_W-1:0]  TIMEOUT_RESET = 24'd100000;
    localparam logic [DUTY_W-1:0] DUTY_FULL     = 14'd10000;
    localparam logic [26:0]       FREQ_SCALE    = 27'd100000000;

    localparam logic [IDX_W-1:0] REG_WINDOW  = 2'd0;
    localparam logic [IDX_W-1:0] REG_TIMEOUT = 2'd1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_TIMEOUT = 2'd1;
    localparam logic [1:0] STAT_NOSIG   = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAIT_LOW, PH_WAIT_HIGH, PH_MEAS_HIGH, PH_MEAS_LOW
    } phase_t;

    typedef enum logic [3:0] {
        C_READY, C_MUL, C_DGO, C_DWAIT, C_FWAIT, C_ACC,
        C_AD_WAIT, C_AP_WAIT, C_AF_WAIT, C_OUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        DS_DUTY, DS_FREQ, DS_AVG_DUTY, DS_AVG_PER, DS_AVG_FREQ
    } div_sel_t;

    typedef enum logic [1:0] {
        EM_NONE, EM_SIMPLE, EM_SUMMARY
    } emit_t;

    typedef struct packed {
        logic     step;
        logic     mul;
        logic     div_start;
        div_sel_t div_sel;
        logic     store_q;
        logic     acc;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic  rec;
        emit_t emit;
        logic  div_done;
        logic  out_free;
    } sts_t;

endpackage

FILE: design/pwm_capture_statistics.sv
// Top level of the PWM capture statistics block.
// Send a start transaction (s_tuser = 1), then one tick transaction per microsecond with
// the pin sample in s_tdata[0]. The block waits for low then high, opens the window at the
// rising edge and reports one summary on m_* at timeout or window end (m_tuser: 0 ok,
// 1 timeout, 2 no period). A tick that reports a timeout or no signal passes through the
// output load state. A tick that closes a period runs two divisions and one that ends the
// window with an ok summary three, in turn on the shared one-bit-per-cycle 48-bit divider,
// and no new tick is accepted until they finish. While an earlier result is still held by
// a stalled receiver, a tick that reports waits until it is taken.
module pwm_capture_statistics import pcs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [REG_W-1:0]  cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [0] pin_level, [7:1] zero
    input  logic              s_tuser,   // [0] action
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // cycle_count, duty avg/min/max, period avg/min/max,
                                         // freq avg/min/max
    output logic [1:0]        m_tuser    // [1:0] status
);
    cmd_t cmd;
    sts_t sts;

    pcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pcs_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .action    (s_tuser),
        .pin_level (s_tdata[0]),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );
endmodule

FILE: design/pcs_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
module pcs_divider import pcs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DIVR_W-1:0] divisor,
    output logic [DIV_W-1:0]  quotient,
    output logic              done
);
    localparam int CW = $clog2(DIV_W);
    localparam logic [CW-1:0] LAST = CW'(DIV_W - 1);

    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [DIVR_W-1:0] rem_reg, rem_next, dsr_reg;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next, done_reg, done_next;
    logic [DIVR_W:0]   shifted;
    logic              qbit;

    // One trial subtraction per cycle
    always_comb begin
        shifted  = {rem_reg, dvd_reg[DIV_W-1]};
        qbit     = (shifted >= {1'b0, dsr_reg});
        rem_next = qbit ? DIVR_W'(shifted - {1'b0, dsr_reg}) : shifted[DIVR_W-1:0];
        dvd_next = {dvd_reg[DIV_W-2:0], qbit};
        cnt_next = cnt_reg + 1'b1;
        busy_next = (cnt_reg != LAST);
        done_next = (cnt_reg == LAST);
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end else begin
            done_reg <= 1'b0;
        end
    end

    // Operands and partial results
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;
endmodule

FILE: design/pcs_ctrl.sv
// Sequencer for the capture statistics block: handshake, divisions, output load.
module pcs_ctrl import pcs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);
    ctrl_state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= C_READY;
        else          state_reg <= state_next;
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DS_DUTY;
        s_tready   = 1'b0;
        case (state_reg)
            C_READY: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.step = 1'b1;
                    if (sts.rec) begin
                        state_next = C_MUL;
                    end else if (sts.emit == EM_SUMMARY) begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DS_AVG_DUTY;
                        state_next    = C_AD_WAIT;
                    end else if (sts.emit == EM_SIMPLE) begin
                        state_next = C_OUT;
                    end
                end
            end
            C_MUL: begin
                cmd.mul    = 1'b1;
                state_next = C_DGO;
            end
            C_DGO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_DUTY;
                state_next    = C_DWAIT;
            end
            C_DWAIT: begin
                cmd.div_sel = DS_DUTY;
                if (sts.div_done) begin
                    cmd.store_q   = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = C_FWAIT;
                end
            end
            C_FWAIT: begin
                cmd.div_sel = DS_FREQ;
                if (sts.div_done) begin
                    cmd.store_q = 1'b1;
                    state_next  = C_ACC;
                end
            end
            C_ACC: begin
                cmd.acc    = 1'b1;
                state_next = C_READY;
            end
            C_AD_WAIT: begin
                cmd.div_sel = DS_AVG_DUTY;
                if (sts.div_done) begin
                    cmd.store_q   = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = C_AP_WAIT;
                end
            end
            C_AP_WAIT: begin
                cmd.div_sel = DS_AVG_PER;
                if (sts.div_done) begin
                    cmd.store_q   = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = C_AF_WAIT;
                end
            end
            C_AF_WAIT: begin
                cmd.div_sel = DS_AVG_FREQ;
                if (sts.div_done) begin
                    cmd.store_q = 1'b1;
                    state_next  = C_OUT;
                end
            end
            C_OUT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = C_READY;
                end
            end
            default: state_next = C_READY;
        endcase
        // The divider start in a wait state uses the operand of the next division
        if (cmd.div_start && state_reg == C_DWAIT)   cmd.div_sel = DS_FREQ;
        if (cmd.div_start && state_reg == C_AD_WAIT) cmd.div_sel = DS_AVG_PER;
        if (cmd.div_start && state_reg == C_AP_WAIT) cmd.div_sel = DS_AVG_FREQ;
    end
endmodule

FILE: design/pcs_datapath.sv
// Measurement state, statistics, divider operands and output register.
module pcs_datapath import pcs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [REG_W-1:0]  cfg_data,
    input  logic              action,
    input  logic              pin_level,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,
    output logic [1:0]        m_tuser
);
    localparam int LW = (TICK_WIDTH > REG_W) ? TICK_WIDTH : REG_W;
    localparam logic [TICK_WIDTH-1:0] TMAX = '1;

    logic [REG_W-1:0] window_reg, timeout_reg;
    phase_t ph_reg, ph_next;
    logic [TICK_WIDTH-1:0] we_reg, we_next, lw_reg, lw_next;
    logic [TICK_WIDTH-1:0] rise_reg, rise_next, fall_reg, fall_next;
    logic [TICK_WIDTH-1:0] we_inc, lw_inc, per_t, high_t, lim_w, lim_t;
    logic [LW-1:0] tmax_ext, win_ext, tmo_ext;
    logic timeout, win_end, clear, rec;
    emit_t emit;
    logic [1:0] emit_status;

    logic [PER_W-1:0]  per_cap_reg, high_cap_reg;
    logic [DSUM_W-1:0] prod_reg, dsum_reg;
    logic [PSUM_W-1:0] psum_reg;
    logic [FSUM_W-1:0] fsum_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [DUTY_W-1:0] duty_reg, dmin_reg, dmax_reg, davg_reg;
    logic [FREQ_W-1:0] freq_reg, fmin_reg, fmax_reg, favg_reg;
    logic [PER_W-1:0]  pmin_reg, pmax_reg, pavg_reg;
    logic [1:0]        res_status_reg;
    logic              res_sum_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic [1:0]        out_user_reg;
    div_sel_t          sel_reg;

    logic [DIV_W-1:0]  div_dvd, div_q;
    logic [DIVR_W-1:0] div_dsr;
    logic              div_done;

    // Configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= WINDOW_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_WINDOW)  window_reg  <= cfg_data;
            if (cfg_index == REG_TIMEOUT) timeout_reg <= cfg_data;
        end
    end

    // Limits clamp to the counter range
    always_comb begin
        tmax_ext = LW'(TMAX);
        win_ext  = (LW'(window_reg)  < tmax_ext) ? LW'(window_reg)  : tmax_ext;
        tmo_ext  = (LW'(timeout_reg) < tmax_ext) ? LW'(timeout_reg) : tmax_ext;
        lim_w    = win_ext[TICK_WIDTH-1:0];
        lim_t    = tmo_ext[TICK_WIDTH-1:0];
        we_inc   = (we_reg == TMAX) ? we_reg : we_reg + 1'b1;
        lw_inc   = (lw_reg == TMAX) ? lw_reg : lw_reg + 1'b1;
        timeout  = (lw_inc >= lim_t);
        win_end  = (we_inc >= lim_w);
        per_t    = we_inc - rise_reg;
        high_t   = fall_reg - rise_reg;
    end

    // Evaluate one tick or start transaction
    always_comb begin
        ph_next = ph_reg;  we_next = we_reg;  lw_next = lw_reg;
        rise_next = rise_reg;  fall_next = fall_reg;
        clear = 1'b0;  rec = 1'b0;  emit = EM_NONE;  emit_status = STAT_OK;
        if (action) begin
            clear = 1'b1;  ph_next = PH_WAIT_LOW;
            we_next = '0;  lw_next = '0;  rise_next = '0;  fall_next = '0;
        end else begin
            case (ph_reg)
                PH_WAIT_LOW: begin
                    if (!pin_level) begin
                        ph_next = PH_WAIT_HIGH;  lw_next = '0;
                    end else begin
                        lw_next = lw_inc;
                        if (timeout) begin
                            emit = EM_SIMPLE;  emit_status = STAT_TIMEOUT;  ph_next = PH_IDLE;
                        end
                    end
                end
                PH_WAIT_HIGH: begin
                    if (pin_level) begin
                        ph_next = PH_MEAS_HIGH;  we_next = '0;  rise_next = '0;  lw_next = '0;
                    end else begin
                        lw_next = lw_inc;
                        if (timeout) begin
                            emit = EM_SIMPLE;  emit_status = STAT_TIMEOUT;  ph_next = PH_IDLE;
                        end
                    end
                end
                PH_MEAS_HIGH, PH_MEAS_LOW: begin
                    we_next = we_inc;
                    if (win_end) begin
                        ph_next = PH_IDLE;
                        if (count_reg == '0) begin
                            emit = EM_SIMPLE;  emit_status = STAT_NOSIG;
                        end else begin
                            emit = EM_SUMMARY;
                        end
                    end else if ((ph_reg == PH_MEAS_HIGH) ? !pin_level : pin_level) begin
                        if (ph_reg == PH_MEAS_HIGH) begin
                            fall_next = we_inc;  ph_next = PH_MEAS_LOW;
                        end else begin
                            rec = (per_t != '0) && (high_t <= per_t);
                            rise_next = we_inc;  ph_next = PH_MEAS_HIGH;
                        end
                        lw_next = '0;
                    end else begin
                        lw_next = lw_inc;
                        if (timeout) begin
                            emit = EM_SIMPLE;  emit_status = STAT_TIMEOUT;  ph_next = PH_IDLE;
                        end
                    end
                end
                default: ph_next = PH_IDLE;
            endcase
        end
    end

    // Measurement phase
    always_ff @(posedge aclk) begin
        if (!aresetn) ph_reg <= PH_IDLE;
        else if (cmd.step) ph_reg <= ph_next;
    end

    // Tick counters and edge times
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            we_reg <= '0;  lw_reg <= '0;  rise_reg <= '0;  fall_reg <= '0;
        end else if (cmd.step) begin
            we_reg <= we_next;  lw_reg <= lw_next;
            rise_reg <= rise_next;  fall_reg <= fall_next;
        end
    end

    // Capture the period, form the duty product, latch quotients
    always_ff @(posedge aclk) begin
        if (cmd.step && rec) begin
            per_cap_reg  <= PER_W'(per_t);
            high_cap_reg <= PER_W'(high_t);
        end
        if (cmd.mul) prod_reg <= DSUM_W'(high_cap_reg) * DSUM_W'(DUTY_FULL);
        if (cmd.step) begin
            res_status_reg <= emit_status;
            res_sum_reg    <= (emit == EM_SUMMARY);
        end
        // Remember which division is running so its quotient lands in the right place
        if (cmd.div_start) sel_reg <= cmd.div_sel;
        if (cmd.store_q) begin
            case (sel_reg)
                DS_DUTY:     duty_reg <= DUTY_W'(div_q);
                DS_FREQ:     freq_reg <= FREQ_W'(div_q);
                DS_AVG_DUTY: davg_reg <= DUTY_W'(div_q);
                DS_AVG_PER:  pavg_reg <= PER_W'(div_q);
                DS_AVG_FREQ: favg_reg <= FREQ_W'(div_q);
                default: ;
            endcase
        end
    end

    // Statistics: clear on start, accumulate after each recorded period
    always_ff @(posedge aclk) begin
        if (!aresetn || (cmd.step && clear)) begin
            count_reg <= '0;  dsum_reg <= '0;  psum_reg <= '0;  fsum_reg <= '0;
            dmin_reg <= '1;  dmax_reg <= '0;  pmin_reg <= '1;  pmax_reg <= '0;
            fmin_reg <= '1;  fmax_reg <= '0;
        end else if (cmd.acc) begin
            dsum_reg <= dsum_reg + DSUM_W'(duty_reg);
            psum_reg <= psum_reg + PSUM_W'(per_cap_reg);
            fsum_reg <= fsum_reg + FSUM_W'(freq_reg);
            if (duty_reg < dmin_reg)    dmin_reg <= duty_reg;
            if (duty_reg > dmax_reg)    dmax_reg <= duty_reg;
            if (per_cap_reg < pmin_reg) pmin_reg <= per_cap_reg;
            if (per_cap_reg > pmax_reg) pmax_reg <= per_cap_reg;
            if (freq_reg < fmin_reg)    fmin_reg <= freq_reg;
            if (freq_reg > fmax_reg)    fmax_reg <= freq_reg;
            if (count_reg != '1) count_reg <= count_reg + 1'b1;
        end
    end

    // Divider operands
    always_comb begin
        div_dvd = DIV_W'(prod_reg);
        div_dsr = per_cap_reg;
        case (cmd.div_sel)
            DS_DUTY:     begin div_dvd = DIV_W'(prod_reg);   div_dsr = per_cap_reg; end
            DS_FREQ:     begin div_dvd = DIV_W'(FREQ_SCALE); div_dsr = per_cap_reg; end
            DS_AVG_DUTY: begin div_dvd = DIV_W'(dsum_reg);   div_dsr = count_reg;   end
            DS_AVG_PER:  begin div_dvd = psum_reg;           div_dsr = count_reg;   end
            DS_AVG_FREQ: begin div_dvd = fsum_reg;           div_dsr = count_reg;   end
            default: ;
        endcase
    end

    pcs_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .quotient (div_q),
        .done     (div_done)
    );

    // Output register: drop on transaction, load on command
    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else if (cmd.load_out) out_valid_reg <= 1'b1;
        else if (m_tready) out_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_user_reg <= res_status_reg;
            out_data_reg <= res_sum_reg ?
                {fmax_reg, fmin_reg, favg_reg, pmax_reg, pmin_reg, pavg_reg,
                 dmax_reg, dmin_reg, davg_reg, count_reg} : '0;
        end
    end

    assign sts.rec      = rec;
    assign sts.emit     = emit;
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;
    assign m_tuser      = out_user_reg;
endmodule

FILE: design/pcs_checker.sv
// Port-level checks for the PWM capture statistics block, bound to the top level.
module pcs_checker import pcs_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic [1:0]       m_tuser
);
    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Timeout and no-signal results carry no statistics
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_TIMEOUT || m_tuser == STAT_NOSIG) |-> m_tdata == '0)
        else $error("failure result carries data");

    // Status is one of the defined codes
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_TIMEOUT || m_tuser == STAT_NOSIG))
        else $error("undefined status");

    // An ok summary has at least one period
    a_ok_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_OK |-> m_tdata[CNT_W-1:0] != '0)
        else $error("ok summary with zero periods");
endmodule

bind pwm_capture_statistics pcs_checker u_pcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: bench/pwm_capture_statistics_tb.sv
// Self-checking regression bench for the PWM capture statistics block.
`timescale 1ns / 100ps

module pwm_capture_statistics_tb;
    import pcs_pkg::*;

    localparam int LIMIT_CYCLES = 40000;
    localparam int SETTLE_CYCLES = 300;
    localparam logic [23:0] TICK_MAX = 24'hFFFFFF;

    typedef struct {
        logic [1:0]       status;
        logic [OUT_W-1:0] fields;
    } summary_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [REG_W-1:0]  cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;   // [0] pin_level, [7:1] zero
    logic              s_tuser = 1'b0; // [0] action
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;        // cycle_count, duty avg/min/max, period avg/min/max,
                                       // freq avg/min/max
    logic [1:0]        m_tuser;        // [1:0] status

    pwm_capture_statistics uut (.*);

    always #2 aclk = ~aclk;

    // Predictor state
    logic [REG_W-1:0]  win_reg = WINDOW_RESET;
    logic [REG_W-1:0]  tmo_reg = TIMEOUT_RESET;
    phase_t            pred_phase = PH_IDLE;
    logic [23:0]       elapsed, lvl_wait, rise_t, fall_t, n_periods;
    logic [37:0]       duty_acc;
    logic [47:0]       per_acc, freq_acc;
    logic [13:0]       duty_lo, duty_hi;
    logic [23:0]       per_lo, per_hi;
    logic [25:0]       freq_lo, freq_hi;

    summary_t          summary_q[$];
    int                errors = 0;
    int                n_items = 0;
    int                n_status[3] = '{0, 0, 0};
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                quiet_cycles = 0;

    function automatic logic [23:0] limit_of(logic [23:0] r);
        return (r < TICK_MAX) ? r : TICK_MAX;
    endfunction

    function automatic void clear_stats();
        elapsed = 0; lvl_wait = 0; rise_t = 0; fall_t = 0; n_periods = 0;
        duty_acc = 0; per_acc = 0; freq_acc = 0;
        duty_lo = '1; duty_hi = 0; per_lo = '1; per_hi = 0; freq_lo = '1; freq_hi = 0;
    endfunction

    function automatic void push_simple(logic [1:0] st);
        summary_t s;
        s.status = st;
        s.fields = '0;
        summary_q.push_back(s);
        pred_phase = PH_IDLE;
    endfunction

    function automatic void push_summary();
        summary_t s;
        logic [47:0] n;
        if (n_periods == 0) begin
            push_simple(STAT_NOSIG);
            return;
        end
        n = 48'(n_periods);
        s.status = STAT_OK;
        s.fields = {freq_hi, freq_lo, 26'(freq_acc / n),
                    per_hi, per_lo, 24'(per_acc / n),
                    duty_hi, duty_lo, 14'(48'(duty_acc) / n),
                    n_periods};
        summary_q.push_back(s);
        pred_phase = PH_IDLE;
    endfunction

    // Count one tick of an unfinished wait; true on timeout
    function automatic bit level_timed_out();
        if (lvl_wait < TICK_MAX) lvl_wait++;
        return lvl_wait >= limit_of(tmo_reg);
    endfunction

    function automatic void add_period();
        logic [23:0] period, high;
        logic [13:0] duty;
        logic [25:0] freq;
        period = elapsed - rise_t;
        high = fall_t - rise_t;
        if (period == 0 || high > period) return;
        duty = 14'((64'(high) * 64'd10000) / 64'(period));
        freq = 26'(32'd100000000 / 32'(period));
        duty_acc += 38'(duty);
        per_acc += 48'(period);
        freq_acc += 48'(freq);
        if (duty < duty_lo) duty_lo = duty;
        if (duty > duty_hi) duty_hi = duty;
        if (period < per_lo) per_lo = period;
        if (period > per_hi) per_hi = period;
        if (freq < freq_lo) freq_lo = freq;
        if (freq > freq_hi) freq_hi = freq;
        if (n_periods < TICK_MAX) n_periods++;
    endfunction

    // Advance the predictor by one accepted input transaction
    function automatic void predict_capture(bit action, bit pin);
        if (action) begin
            clear_stats();
            pred_phase = PH_WAIT_LOW;
            return;
        end
        case (pred_phase)
            PH_WAIT_LOW: begin
                if (!pin) begin
                    pred_phase = PH_WAIT_HIGH;
                    lvl_wait = 0;
                end else if (level_timed_out()) push_simple(STAT_TIMEOUT);
            end
            PH_WAIT_HIGH: begin
                if (pin) begin
                    pred_phase = PH_MEAS_HIGH;
                    elapsed = 0; rise_t = 0; lvl_wait = 0;
                end else if (level_timed_out()) push_simple(STAT_TIMEOUT);
            end
            PH_MEAS_HIGH, PH_MEAS_LOW: begin
                if (elapsed < TICK_MAX) elapsed++;
                if (elapsed >= limit_of(win_reg)) push_summary();
                else if (pred_phase == PH_MEAS_HIGH) begin
                    if (!pin) begin
                        fall_t = elapsed;
                        pred_phase = PH_MEAS_LOW;
                        lvl_wait = 0;
                    end else if (level_timed_out()) push_simple(STAT_TIMEOUT);
                end else begin
                    if (pin) begin
                        add_period();
                        rise_t = elapsed;
                        pred_phase = PH_MEAS_HIGH;
                        lvl_wait = 0;
                    end else if (level_timed_out()) push_simple(STAT_TIMEOUT);
                end
            end
            default: pred_phase = PH_IDLE;
        endcase
    endfunction

    // Send one input transaction, idling beforehand at the current rate
    task automatic send_item(bit action, bit pin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= action;
        s_tdata <= {7'b0, pin};
        do @(posedge aclk); while (!s_tready);
        predict_capture(action, pin);
        n_items++;
    endtask

    task automatic end_stream();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait out every expected summary and any divide still running
    task automatic drain();
        end_stream();
        while (summary_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_WINDOW) win_reg = val;
        else if (idx == REG_TIMEOUT) tmo_reg = val;
    endtask

    task automatic set_regs(logic [REG_W-1:0] win, logic [REG_W-1:0] tmo);
        drain();
        write_reg(REG_WINDOW, win);
        write_reg(REG_TIMEOUT, tmo);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_pins(logic [31:0] bits, int n);
        for (int i = 0; i < n; i++) send_item(1'b0, bits[i]);
    endtask

    // Measurement, restart and timeout on a short window
    task automatic test_basic_window();
        set_regs(24'd40, 24'd6);
        send_pins(32'b11, 2);                 // idle ticks are dropped
        send_item(1'b1, 1'b0);
        send_pins(32'b10_1001_1101, 10);      // wait low, rise, two periods
        send_item(1'b1, 1'b1);                // restart mid-window
        send_pins(32'b11_1111, 6);            // no low level: timeout
        drain();
    endtask

    // Window that closes before any full period
    task automatic test_no_signal();
        set_regs(24'd3, TICK_MAX);
        send_item(1'b1, 1'b0);
        send_pins(32'b0_0010, 5);
        drain();
    endtask

    // Zero registers: instant timeout and instant window end
    task automatic test_zero_regs();
        set_regs(24'd0, 24'd0);
        send_item(1'b1, 1'b1);
        send_pins(32'b1, 1);
        send_item(1'b1, 1'b0);
        send_pins(32'b0, 1);
        send_item(1'b1, 1'b0);
        send_pins(32'b110, 3);
        drain();
    endtask

    // Largest register values, then a pin held high into timeout
    task automatic test_max_regs();
        set_regs(TICK_MAX, TICK_MAX);
        send_item(1'b1, 1'b1);
        send_pins(32'b1010, 4);
        set_regs(24'd1000, 24'd2);
        send_item(1'b1, 1'b0);
        send_pins(32'b0011, 4);
        drain();
    endtask

    // Random PWM runs with noise, restarts and register changes
    task automatic test_random_runs(int budget);
        int stop_at, hi_len, lo_len, ticks;
        bit lvl;
        stop_at = n_items + budget;
        while (n_items < stop_at) begin
            if ($urandom_range(99) < 30)
                set_regs(24'($urandom_range(1, ($urandom_range(9) == 0) ? 600 : 80)),
                         24'($urandom_range(1, ($urandom_range(4) == 0) ? 4 : 40)));
            hi_len = $urandom_range(1, 9);
            lo_len = $urandom_range(1, 9);
            send_item(1'b1, 1'($urandom_range(1)));
            lvl = 1'b1;
            ticks = 0;
            while (pred_phase != PH_IDLE) begin
                if ($urandom_range(99) < 8) send_item(1'b0, 1'($urandom_range(1)));
                else if ($urandom_range(199) == 0) send_item(1'b1, 1'($urandom_range(1)));
                else send_item(1'b0, lvl);
                ticks++;
                if (ticks >= (lvl ? hi_len : lo_len)) begin
                    lvl = ~lvl;
                    ticks = 0;
                    if ($urandom_range(3) == 0) begin
                        hi_len = $urandom_range(1, 12);
                        lo_len = $urandom_range(1, 12);
                    end
                end
            end
        end
        drain();
    endtask

    // Receiver stalls at the current rate
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each summary with the oldest one predicted
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            summary_t exp_s;
            int widths[10] = '{24, 14, 14, 14, 24, 24, 24, 26, 26, 26};
            int offs;
            logic [31:0] e_f, a_f;
            if (summary_q.size() == 0) begin
                $display("%0t: unexpected summary status %0d data %h", $time, m_tuser,
                         m_tdata);
                errors++;
            end else begin
                exp_s = summary_q.pop_front();
                if (exp_s.status <= STAT_NOSIG) n_status[exp_s.status]++;
                if (m_tuser !== exp_s.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_s.status,
                             m_tuser);
                    errors++;
                end
                offs = 0;
                for (int f = 0; f < 10; f++) begin
                    e_f = 32'((exp_s.fields >> offs) & ((216'd1 << widths[f]) - 1));
                    a_f = 32'((m_tdata >> offs) & ((216'd1 << widths[f]) - 1));
                    if (a_f !== e_f) begin
                        $display("%0t: field %0d expected %0d actual %0d", $time, f, e_f,
                                 a_f);
                        errors++;
                    end
                    offs += widths[f];
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= LIMIT_CYCLES) begin
            $display("%0t: no transaction for %0d cycles", $time, LIMIT_CYCLES);
            $display("pwm_capture_statistics regression: fail");
            $finish;
        end
    end

    initial begin
        clear_stats();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_window();
        test_no_signal();
        test_zero_regs();
        test_max_regs();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random_runs(310);
        send_idle_pct = 53; recv_stall_pct = 0;  test_random_runs(310);
        send_idle_pct = 0;  recv_stall_pct = 53; test_random_runs(310);
        send_idle_pct = 28; recv_stall_pct = 28; test_random_runs(310);
        if (summary_q.size() != 0) begin
            $display("%0t: %0d summaries never arrived", $time, summary_q.size());
            errors++;
        end
        $display("Sent %0d input transactions; summaries ok %0d, timeout %0d, no signal %0d.",
                 n_items, n_status[0], n_status[1], n_status[2]);
        $display("Mismatches found: %0d", errors);
        if (errors == 0)
            $display("pwm_capture_statistics regression: pass");
        else
            $display("pwm_capture_statistics regression: fail");
        $finish;
    end

endmodule
